/* rtl/core/assert_macros.svh */
// Assertion macros shared by the convolution core.
// Needs nothing else; include it in files that hold concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is asserted.
`define C3ZP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define C3ZP_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/c3zp_pkg.sv */
// Shared constants, types and helpers of the 3x3 zero-padded convolution core.
// No dependencies; the core modules and interfaces refer to it by scoped names.
package c3zp_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;
	localparam int KERNEL_SIZE = 3;

	localparam int PIX_W     = 8;
	localparam int SIZE_W    = 12;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int IN_ROW_W  = 12;
	localparam int WGT_W     = 16;
	localparam int COEF_W    = KERNEL_SIZE * WGT_W;
	localparam int PROD_W    = PIX_W + 1 + WGT_W;
	localparam int CSUM_W    = PROD_W + 2;
	localparam int VALUE_W   = 28;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = 6;
	localparam int REG_IDX_W = 3;
	localparam int LS_W      = 2 * PIX_W;

	localparam logic [REG_IDX_W-1:0] REG_WIDTH       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF_TOP    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_COEF_MIDDLE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd4;

	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;
	// +1.0 left, 0 middle, -1.0 right
	localparam logic [COEF_W-1:0] COEF_RESET   = 48'hFF00_0000_0100;

	typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] column_t;
	typedef logic [KERNEL_SIZE-1:0][WGT_W-1:0] wcol_t;

	typedef struct packed {
		logic [SIZE_W-1:0]                                   width;
		logic [SIZE_W-1:0]                                   height;
		logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][WGT_W-1:0] coef;   // [row][col]
	} cfg_t;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} bound_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             res;
		bound_t           bnd;
		logic             last;
	} pos_t;

	typedef struct packed {
		logic                   shift;
		logic                   mul_en;
		logic                   sum_en;
		logic [KERNEL_SIZE-1:0] kill;
	} cell_ctrl_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* rtl/core/c3zp_pix_if.sv */
// Input channel of the convolution core: one pixel or padding item per handshake.
// Depends on c3zp_pkg for the sample width.
interface c3zp_pix_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [c3zp_pkg::PIX_W-1:0]  pixel;

	modport source(output valid, kind, pixel, input ready);
	modport sink(input valid, kind, pixel, output ready);
endinterface

/* rtl/core/c3zp_res_if.sv */
// Result channel of the convolution core: one window sum per handshake.
// Depends on c3zp_pkg for the result width.
interface c3zp_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [c3zp_pkg::VALUE_W-1:0] value;
	logic                                frame_end;

	modport source(output valid, value, frame_end, input ready);
	modport sink(input valid, value, frame_end, output ready);
endinterface

/* rtl/core/c3zp_regs.sv */
// APB-style configuration registers: frame size and three rows of kernel weights.
// Depends on c3zp_pkg.
module c3zp_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [c3zp_pkg::ADDR_W-1:0]   paddr,
	input  logic [c3zp_pkg::DATA_W-1:0]   pwdata,
	output logic [c3zp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output c3zp_pkg::cfg_t                cfg
);

	logic [c3zp_pkg::SIZE_W-1:0]    width_q;
	logic [c3zp_pkg::SIZE_W-1:0]    height_q;
	logic [c3zp_pkg::COEF_W-1:0]    coef_q [c3zp_pkg::KERNEL_SIZE];
	logic [c3zp_pkg::REG_IDX_W-1:0] idx;
	logic                           wr;

	assign idx    = paddr[c3zp_pkg::ADDR_W-1:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= c3zp_pkg::WIDTH_RESET;
			height_q <= c3zp_pkg::HEIGHT_RESET;
			for (int r = 0; r < c3zp_pkg::KERNEL_SIZE; r++) begin
				coef_q[r] <= c3zp_pkg::COEF_RESET;
			end
		end else if (wr) begin
			unique case (idx)
				c3zp_pkg::REG_WIDTH:       width_q   <= pwdata[c3zp_pkg::SIZE_W-1:0];
				c3zp_pkg::REG_HEIGHT:      height_q  <= pwdata[c3zp_pkg::SIZE_W-1:0];
				c3zp_pkg::REG_COEF_TOP:    coef_q[0] <= pwdata[c3zp_pkg::COEF_W-1:0];
				c3zp_pkg::REG_COEF_MIDDLE: coef_q[1] <= pwdata[c3zp_pkg::COEF_W-1:0];
				c3zp_pkg::REG_COEF_BOTTOM: coef_q[2] <= pwdata[c3zp_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			c3zp_pkg::REG_WIDTH:       prdata = c3zp_pkg::DATA_W'(width_q);
			c3zp_pkg::REG_HEIGHT:      prdata = c3zp_pkg::DATA_W'(height_q);
			c3zp_pkg::REG_COEF_TOP:    prdata = c3zp_pkg::DATA_W'(coef_q[0]);
			c3zp_pkg::REG_COEF_MIDDLE: prdata = c3zp_pkg::DATA_W'(coef_q[1]);
			c3zp_pkg::REG_COEF_BOTTOM: prdata = c3zp_pkg::DATA_W'(coef_q[2]);
			default:                   prdata = '0;
		endcase
	end

	// Clamp sizes to 1..max; split each row into its three weights.
	always_comb begin
		cfg.width  = c3zp_pkg::clamp_size(width_q, c3zp_pkg::SIZE_W'(c3zp_pkg::MAX_WIDTH));
		cfg.height = c3zp_pkg::clamp_size(height_q, c3zp_pkg::SIZE_W'(c3zp_pkg::MAX_HEIGHT));
		for (int r = 0; r < c3zp_pkg::KERNEL_SIZE; r++) begin
			for (int c = 0; c < c3zp_pkg::KERNEL_SIZE; c++) begin
				cfg.coef[r][c] = coef_q[r][c*c3zp_pkg::WGT_W +: c3zp_pkg::WGT_W];
			end
		end
	end

endmodule

/* rtl/core/c3zp_scan.sv */
// Raster position tracking: input column/row, output column/row, edge flags.
// Depends on c3zp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module c3zp_scan (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  c3zp_pkg::cfg_t cfg,
	output c3zp_pkg::pos_t pos
);

	logic [c3zp_pkg::COL_W-1:0]    in_col_q;
	logic [c3zp_pkg::IN_ROW_W-1:0] in_row_q;
	logic [c3zp_pkg::COL_W-1:0]    out_col_q;
	logic [c3zp_pkg::ROW_W-1:0]    out_row_q;
	logic                          in_wrap;

	assign in_wrap = (c3zp_pkg::SIZE_W'(in_col_q) + c3zp_pkg::SIZE_W'(1)) >= cfg.width;

	always_comb begin
		pos.col        = in_col_q;
		pos.res        = (in_row_q >= c3zp_pkg::IN_ROW_W'(2))
			|| (in_row_q == c3zp_pkg::IN_ROW_W'(1) && in_col_q != '0);
		pos.bnd.top    = out_row_q == '0;
		pos.bnd.bottom = (c3zp_pkg::SIZE_W'(out_row_q) + c3zp_pkg::SIZE_W'(1)) >= cfg.height;
		pos.bnd.left   = out_col_q == '0;
		pos.bnd.right  = (c3zp_pkg::SIZE_W'(out_col_q) + c3zp_pkg::SIZE_W'(1)) >= cfg.width;
		pos.last       = pos.bnd.bottom && pos.bnd.right;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (pos.res && pos.last) begin
				// last result of the frame: start over at pixel zero
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_wrap) begin
					in_col_q <= '0;
					if (in_row_q != '1) begin
						in_row_q <= in_row_q + c3zp_pkg::IN_ROW_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + c3zp_pkg::COL_W'(1);
				end
				if (pos.res) begin
					if (pos.bnd.right) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + c3zp_pkg::ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + c3zp_pkg::COL_W'(1);
					end
				end
			end
		end
	end

	`C3ZP_ASSERT(a_frame_restart, clk, arst_n, accept && pos.res && pos.last |=> in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0, "position not cleared after frame end")

endmodule

/* rtl/core/c3zp_linestore.sv */
// Two line stores held as one memory of {upper, lower} byte pairs per column.
// Registered read; a write to the address read in the same cycle is forwarded.
// Depends on c3zp_pkg.
module c3zp_linestore (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [c3zp_pkg::COL_W-1:0]  rd_addr,
	input  logic                        wr_en,
	input  logic [c3zp_pkg::COL_W-1:0]  wr_addr,
	input  logic [c3zp_pkg::LS_W-1:0]   wr_data,
	output logic [c3zp_pkg::LS_W-1:0]   rd_data
);

	logic [c3zp_pkg::LS_W-1:0] mem [c3zp_pkg::MAX_WIDTH];
	logic [c3zp_pkg::LS_W-1:0] rd_q;
	logic [c3zp_pkg::LS_W-1:0] fwd_data_q;
	logic                      fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;

endmodule

/* rtl/core/c3zp_cell.sv */
// One window column cell: holds three samples, multiplies by its column of weights
// and adds the three products. Depends on c3zp_pkg.
module c3zp_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  c3zp_pkg::cell_ctrl_t                 ctrl,
	input  c3zp_pkg::column_t                    col_in,
	output c3zp_pkg::column_t                    col_out,
	input  c3zp_pkg::wcol_t                      weight,
	output logic signed [c3zp_pkg::CSUM_W-1:0]   csum
);

	c3zp_pkg::column_t                   col_q;
	logic signed [c3zp_pkg::PROD_W-1:0]  prod_d  [c3zp_pkg::KERNEL_SIZE];
	logic signed [c3zp_pkg::PROD_W-1:0]  prod_s3 [c3zp_pkg::KERNEL_SIZE];
	logic signed [c3zp_pkg::CSUM_W-1:0]  csum_d;
	logic signed [c3zp_pkg::CSUM_W-1:0]  csum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// Samples outside the frame count as zero.
	always_comb begin
		for (int r = 0; r < c3zp_pkg::KERNEL_SIZE; r++) begin
			if (ctrl.kill[r]) begin
				prod_d[r] = '0;
			end else begin
				prod_d[r] = c3zp_pkg::PROD_W'($signed({1'b0, col_q[r]}))
					* c3zp_pkg::PROD_W'($signed(weight[r]));
			end
		end
	end

	always_comb begin
		csum_d = '0;
		for (int r = 0; r < c3zp_pkg::KERNEL_SIZE; r++) begin
			csum_d = csum_d + c3zp_pkg::CSUM_W'(prod_s3[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s3 <= prod_d;
		end
		if (ctrl.sum_en) begin
			csum_s4 <= csum_d;
		end
	end

	assign csum = csum_s4;

endmodule

/* rtl/core/conv3x3_zero_pad_stream_top.sv */
// Streaming 3x3 convolution with zero padding; each result leaves from the total stage register.
// Throughput: one item per cycle unless the result channel holds off; the first result of a frame needs width+2 items.
// Rate is set by the five-stage pipeline: read, window shift, multiply, column add, total.
// Reset clears positions, valid bits and window, restores 640x480 and the default kernel.
// Line stores are not cleared; entries never written are masked by the top edge.
// Depends on c3zp_pkg, both channel interfaces, the cells, line store, scan and registers.
`include "assert_macros.svh"

module conv3x3_zero_pad_stream_top (
	input  logic                          clk,
	input  logic                          arst_n,
	c3zp_pix_if.sink                      pix,
	c3zp_res_if.source                    res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [c3zp_pkg::ADDR_W-1:0]   paddr,
	input  logic [c3zp_pkg::DATA_W-1:0]   pwdata,
	output logic [c3zp_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int KS = c3zp_pkg::KERNEL_SIZE;

	c3zp_pkg::cfg_t cfg;
	c3zp_pkg::pos_t pos;

	// Stage valids and load enables. A stage loads when it is empty or
	// its content moves on, so bubbles collapse under backpressure.
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic load1, load2, load3, load4, load5;
	logic accept;
	logic mv1;

	// Stage 1: sample and its position, line store read in flight
	logic [c3zp_pkg::PIX_W-1:0] sample_s1;
	logic [c3zp_pkg::COL_W-1:0] col_s1;
	logic                       res_s1;
	c3zp_pkg::bound_t           bnd_s1;
	logic                       last_s1;

	// Stage 2: window holds this item's neighborhood
	logic                       res_s2;
	c3zp_pkg::bound_t           bnd_s2;
	logic                       last_s2;
	logic                       zero_q;

	logic                       last_s3;
	logic                       last_s4;
	logic                       last_s5;
	logic signed [c3zp_pkg::VALUE_W-1:0] value_s5;
	logic signed [c3zp_pkg::VALUE_W-1:0] value_d;

	logic [c3zp_pkg::LS_W-1:0]  ls_rd;
	logic [c3zp_pkg::PIX_W-1:0] up_eff;
	logic [c3zp_pkg::PIX_W-1:0] lo_eff;

	c3zp_pkg::column_t                  cell_in   [KS];
	c3zp_pkg::column_t                  cell_out  [KS];
	c3zp_pkg::wcol_t                    cell_wgt  [KS];
	c3zp_pkg::cell_ctrl_t               cell_ctrl [KS];
	logic signed [c3zp_pkg::CSUM_W-1:0] cell_csum [KS];

	assign load5  = !v5_q || res.ready;
	assign load4  = !v4_q || load5;
	assign load3  = !v3_q || load4;
	assign load2  = !v2_q || load3;
	assign load1  = !v1_q || load2;
	assign accept = pix.valid && load1;
	assign mv1    = v1_q && load2;

	assign pix.ready     = load1;
	assign res.valid     = v5_q;
	assign res.value     = value_s5;
	assign res.frame_end = last_s5;

	c3zp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Track where the next item lands and which result it completes.
	c3zp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cfg    (cfg),
		.pos    (pos)
	);

	// Read both line stores at the item's column on accept; write back the
	// shifted pair when the item moves into the window.
	c3zp_linestore u_linestore (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pos.col),
		.wr_en   (mv1),
		.wr_addr (col_s1),
		.wr_data ({lo_eff, sample_s1}),
		.rd_data (ls_rd)
	);

	assign up_eff = ls_rd[c3zp_pkg::LS_W-1:c3zp_pkg::PIX_W];
	assign lo_eff = ls_rd[c3zp_pkg::PIX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			v2_q   <= 1'b0;
			v3_q   <= 1'b0;
			v4_q   <= 1'b0;
			v5_q   <= 1'b0;
			zero_q <= 1'b1;
		end else begin
			if (load1) begin
				v1_q <= pix.valid;
			end
			if (load2) begin
				v2_q <= v1_q;
			end
			// drop items that complete no result
			if (load3) begin
				v3_q <= v2_q && res_s2;
			end
			if (load4) begin
				v4_q <= v3_q;
			end
			if (load5) begin
				v5_q <= v4_q;
			end
			// after the frame's last result the next shift starts from an empty window
			if (mv1) begin
				zero_q <= last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= pix.kind ? '0 : pix.pixel;
			col_s1    <= pos.col;
			res_s1    <= pos.res;
			bnd_s1    <= pos.bnd;
			last_s1   <= pos.res && pos.last;
		end
		if (mv1) begin
			res_s2  <= res_s1;
			bnd_s2  <= bnd_s1;
			last_s2 <= last_s1;
		end
		if (load3) begin
			last_s3 <= last_s2;
		end
		if (load4) begin
			last_s4 <= last_s3;
		end
		if (load5) begin
			last_s5  <= last_s4;
			value_s5 <= value_d;
		end
	end

	// Feed the newest column to the right cell and pass columns leftward;
	// hand zeros across when the window restarts.
	always_comb begin
		cell_in[KS-1] = {sample_s1, lo_eff, up_eff};
		for (int c = 0; c < KS - 1; c++) begin
			cell_in[c] = zero_q ? '0 : cell_out[c+1];
		end
	end

	// Weights and edge masks per cell: top/bottom kill a row, left/right a column.
	always_comb begin
		for (int c = 0; c < KS; c++) begin
			cell_ctrl[c].shift  = mv1;
			cell_ctrl[c].mul_en = load3;
			cell_ctrl[c].sum_en = load4;
			for (int r = 0; r < KS; r++) begin
				cell_wgt[c][r]     = cfg.coef[r][c];
				cell_ctrl[c].kill[r] = (r == 0 && bnd_s2.top) || (r == KS - 1 && bnd_s2.bottom)
					|| (c == 0 && bnd_s2.left) || (c == KS - 1 && bnd_s2.right);
			end
		end
	end

	for (genvar c = 0; c < KS; c++) begin : g_cell
		c3zp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cell_ctrl[c]),
			.col_in  (cell_in[c]),
			.col_out (cell_out[c]),
			.weight  (cell_wgt[c]),
			.csum    (cell_csum[c])
		);
	end

	always_comb begin
		value_d = '0;
		for (int c = 0; c < KS; c++) begin
			value_d = value_d + c3zp_pkg::VALUE_W'(cell_csum[c]);
		end
	end

	`C3ZP_NEVER(a_last_clears_window, clk, arst_n, v2_q && last_s2 && !zero_q, "window not marked empty after frame end")
	`C3ZP_ASSERT(a_stall_only_full, clk, arst_n, !pix.ready |-> v1_q && v2_q && v3_q && v4_q && v5_q && !res.ready, "input held off while a stage is free")

endmodule
